// ----- rtl/horizontal_box_shrink_u8_core_assert.svh -----
// Assertion macros used by the checker file.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef HORIZONTAL_BOX_SHRINK_U8_CORE_ASSERT_SVH
`define HORIZONTAL_BOX_SHRINK_U8_CORE_ASSERT_SVH

// same-cycle implication
`define HBS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hbs assertion failed");

// next-cycle implication
`define HBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hbs assertion failed");

`endif

// ----- rtl/hbs_pkg.sv -----
package hbs_pkg;

   localparam int LANES      = 4;
   localparam int MAX_BANDS  = 4;
   localparam int MAX_SHRINK = 256;
   localparam int SAMPLE_W   = 8;
   localparam int SUM_W      = 17;
   localparam int COUNT_W    = 8;
   localparam int SHRINK_W   = 9;
   localparam int BAND_W     = 3;
   localparam int RECIP_W    = 25;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam int KEEP_SHIFT = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SHRINK     = 2'd0,
      REG_BAND_COUNT = 2'd1,
      REG_RECIPROCAL = 2'd2
   } reg_index_type;

   typedef logic [LANES-1:0][SAMPLE_W-1:0] samples_type;
   typedef logic [LANES-1:0][SUM_W-1:0]    sums_type;

   typedef struct packed {
      sums_type sums;
      logic     row_end;
   } entry_type;

   typedef struct packed {
      logic [SHRINK_W-1:0] run_len;
      logic [BAND_W-1:0]   lanes;
      logic [RECIP_W-1:0]  reciprocal;
      logic                reload;
      logic [SUM_W-1:0]    reload_start;
   } cfg_type;

   // shrink of zero counts as one, large values clamp
   function automatic logic [SHRINK_W-1:0] norm_shrink(input logic [SHRINK_W-1:0] raw);
      logic [SHRINK_W-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = SHRINK_W'(1);
      end else if (raw > SHRINK_W'(MAX_SHRINK)) begin
         n = SHRINK_W'(MAX_SHRINK);
      end
      return n;
   endfunction

   function automatic logic [BAND_W-1:0] norm_bands(input logic [BAND_W-1:0] raw);
      logic [BAND_W-1:0] n;
      n = raw;
      if (raw > BAND_W'(MAX_BANDS)) begin
         n = BAND_W'(MAX_BANDS);
      end
      return n;
   endfunction

endpackage

// ----- rtl/hbs_if.sv -----
interface hbs_req_if;
   logic                         valid;
   logic                         ready;
   logic [hbs_pkg::SAMPLE_W-1:0] in_band0;
   logic [hbs_pkg::SAMPLE_W-1:0] in_band1;
   logic [hbs_pkg::SAMPLE_W-1:0] in_band2;
   logic [hbs_pkg::SAMPLE_W-1:0] in_band3;
   logic                         last_in_row;

   modport source (output valid, in_band0, in_band1, in_band2, in_band3, last_in_row,
                   input ready);
   modport sink   (input valid, in_band0, in_band1, in_band2, in_band3, last_in_row,
                   output ready);
   modport monitor (input valid, ready, in_band0, in_band1, in_band2, in_band3,
                    last_in_row);
endinterface

interface hbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hbs_pkg::SAMPLE_W-1:0] out_band0;
   logic [hbs_pkg::SAMPLE_W-1:0] out_band1;
   logic [hbs_pkg::SAMPLE_W-1:0] out_band2;
   logic [hbs_pkg::SAMPLE_W-1:0] out_band3;
   logic                         row_end;

   modport source (output valid, out_band0, out_band1, out_band2, out_band3, row_end,
                   input ready);
   modport sink   (input valid, out_band0, out_band1, out_band2, out_band3, row_end,
                   output ready);
   modport monitor (input valid, ready, out_band0, out_band1, out_band2, out_band3,
                    row_end);
endinterface

interface hbs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hbs_pkg::CSR_IDX_W-1:0]  index;
   logic [hbs_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

// ----- rtl/horizontal_box_shrink_u8_core.sv -----
// After the last pixel of a run is accepted, its sums are written into the queue and then
// into the scaler output register.
// Throughput: one pixel word per cycle unless the queue is full; the per-band add loop bounds it.
// Output stalls are absorbed by a two-entry queue ahead of the scaler register.
// Reset (synchronous, active high): shrink 1, band count 1, reciprocal 2^24,
// sums and run count cleared, queue and output empty. No clearing pass.
module horizontal_box_shrink_u8_core (
   input  logic      clock,
   input  logic      reset,
   hbs_req_if.sink   req_if,
   hbs_rsp_if.source rsp_if,
   hbs_csr_if.sink   csr_if
);

   // configuration registers; shrink and band count stored already normalized
   logic [hbs_pkg::SHRINK_W-1:0] run_len_ff;
   logic [hbs_pkg::BAND_W-1:0]   lanes_ff;
   logic [hbs_pkg::RECIP_W-1:0]  recip_ff;

   logic                         csr_write;
   logic [hbs_pkg::SHRINK_W-1:0] new_len;
   hbs_pkg::cfg_type             cfg;

   // queue handshake between front and back
   logic                         push;
   logic                         pop;
   logic                         queue_full;
   logic                         head_valid;
   hbs_pkg::entry_type           push_entry;
   hbs_pkg::entry_type           head;

   // writes are always taken
   assign csr_if.ready = 1'b1;
   assign csr_write = csr_if.valid && csr_if.ready;
   assign new_len = hbs_pkg::norm_shrink(csr_if.data[hbs_pkg::SHRINK_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff <= hbs_pkg::SHRINK_W'(1);
         lanes_ff   <= hbs_pkg::BAND_W'(1);
         recip_ff   <= hbs_pkg::RECIP_W'(1 << hbs_pkg::KEEP_SHIFT);
      end else if (csr_write) begin
         unique case (csr_if.index)
            hbs_pkg::REG_SHRINK: begin
               run_len_ff <= new_len;
            end
            hbs_pkg::REG_BAND_COUNT: begin
               lanes_ff <= hbs_pkg::norm_bands(csr_if.data[hbs_pkg::BAND_W-1:0]);
            end
            hbs_pkg::REG_RECIPROCAL: begin
               recip_ff <= csr_if.data[hbs_pkg::RECIP_W-1:0];
            end
            default: begin
               // index beyond the register list: ignored
            end
         endcase
      end
   end

   // a shrink write restarts the run with the new half-length bias,
   // taken from the write data so it lands on the same edge
   always_comb begin
      cfg.run_len      = run_len_ff;
      cfg.lanes        = lanes_ff;
      cfg.reciprocal   = recip_ff;
      cfg.reload       = csr_write && (csr_if.index == hbs_pkg::REG_SHRINK);
      cfg.reload_start = hbs_pkg::SUM_W'(new_len >> 1);
   end

   hbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   hbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

// ----- rtl/hbs_front.sv -----
// Accumulates each run of pixels and pushes the finished sums to the queue.
module hbs_front (
   input  logic                clock,
   input  logic                reset,
   hbs_req_if.sink             req_if,
   input  hbs_pkg::cfg_type    cfg,
   input  logic                queue_full,
   output logic                push,
   output hbs_pkg::entry_type  push_entry
);

   hbs_pkg::sums_type              sums_ff, sums_in;
   logic [hbs_pkg::COUNT_W-1:0]    count_ff, count_in;
   hbs_pkg::samples_type           band_w;
   hbs_pkg::sums_type              sum_add;
   logic [hbs_pkg::SUM_W-1:0]      start_w;
   logic                           accept;
   logic                           run_done;

   assign band_w = {req_if.in_band3, req_if.in_band2, req_if.in_band1, req_if.in_band0};
   assign req_if.ready = !queue_full;
   assign accept = req_if.valid && req_if.ready;
   assign start_w = hbs_pkg::SUM_W'(cfg.run_len >> 1);
   // count+1 reaching the run length closes the run
   assign run_done = ({1'b0, count_ff} + hbs_pkg::SHRINK_W'(1)) >= cfg.run_len;

   always_comb begin
      for (int i = 0; i < hbs_pkg::LANES; i++) begin
         sum_add[i] = sums_ff[i] + hbs_pkg::SUM_W'(band_w[i]);
      end
   end

   assign push = accept && run_done;
   assign push_entry.sums = sum_add;
   assign push_entry.row_end = req_if.last_in_row;

   always_comb begin
      sums_in  = sums_ff;
      count_in = count_ff;
      if (cfg.reload) begin
         sums_in  = {hbs_pkg::LANES{cfg.reload_start}};
         count_in = '0;
      end else if (accept) begin
         if (run_done || req_if.last_in_row) begin
            sums_in  = {hbs_pkg::LANES{start_w}};
            count_in = '0;
         end else begin
            sums_in  = sum_add;
            count_in = count_ff + hbs_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff  <= '0;
         count_ff <= '0;
      end else begin
         sums_ff  <= sums_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/hbs_queue.sv -----
// Small register FIFO between the accumulator and the scaler.
module hbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hbs_pkg::entry_type  push_entry,
   input  logic                pop,
   output hbs_pkg::entry_type  head,
   output logic                head_valid,
   output logic                full
);

   hbs_pkg::entry_type               entry_ff [hbs_pkg::QUEUE_DEPTH];
   logic [hbs_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [hbs_pkg::QPTR_W:0]         count_ff;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign full       = count_ff == (hbs_pkg::QPTR_W + 1)'(hbs_pkg::QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + hbs_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + hbs_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (hbs_pkg::QPTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (hbs_pkg::QPTR_W + 1)'(1);
         end
      end
   end

endmodule

// ----- rtl/hbs_back.sv -----
// Scales queued sums by the reciprocal and holds the result word.
module hbs_back (
   input  logic                clock,
   input  logic                reset,
   input  hbs_pkg::cfg_type    cfg,
   input  hbs_pkg::entry_type  head,
   input  logic                head_valid,
   output logic                pop,
   hbs_rsp_if.source           rsp_if
);

   logic [hbs_pkg::PROD_W-1:0]  prod   [hbs_pkg::LANES];
   hbs_pkg::samples_type        scaled;
   hbs_pkg::samples_type        out_ff;
   logic                        row_end_ff;
   logic                        valid_ff;

   assign pop = head_valid && (!valid_ff || rsp_if.ready);

   always_comb begin
      for (int i = 0; i < hbs_pkg::LANES; i++) begin
         prod[i] = hbs_pkg::PROD_W'(head.sums[i]) * hbs_pkg::PROD_W'(cfg.reciprocal);
         // bands at or above the band count read as zero
         if (hbs_pkg::BAND_W'(i) < cfg.lanes) begin
            scaled[i] = prod[i][hbs_pkg::KEEP_SHIFT +: hbs_pkg::SAMPLE_W];
         end else begin
            scaled[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff     <= scaled;
         row_end_ff <= head.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.out_band0 = out_ff[0];
   assign rsp_if.out_band1 = out_ff[1];
   assign rsp_if.out_band2 = out_ff[2];
   assign rsp_if.out_band3 = out_ff[3];
   assign rsp_if.row_end   = row_end_ff;

endmodule

// ----- rtl/hbs_checker.sv -----
`include "horizontal_box_shrink_u8_core_assert.svh"

module hbs_checker (
   input logic        clock,
   input logic        reset,
   hbs_req_if.sink    req_if,
   hbs_rsp_if.source  rsp_if
);

   logic        req_acc;
   logic        rsp_acc;
   logic [31:0] credit_ff;

   assign req_acc = req_if.valid && req_if.ready;
   assign rsp_acc = rsp_if.valid && rsp_if.ready;

   // pixel words in minus result words out
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_ff + 32'(req_acc) - 32'(rsp_acc);
      end
   end

   `HBS_ASSERT_NEXT(a_rsp_hold, rsp_if.valid && !rsp_if.ready, rsp_if.valid && $stable(rsp_if.out_band0) && $stable(rsp_if.out_band1) && $stable(rsp_if.out_band2) && $stable(rsp_if.out_band3) && $stable(rsp_if.row_end))
   `HBS_ASSERT_IMPLY(a_no_early_rsp, rsp_acc, credit_ff != '0)
   `HBS_ASSERT_IMPLY(a_rsp_idle_after_reset, $past(reset), !rsp_if.valid)

endmodule

bind horizontal_box_shrink_u8_core hbs_checker u_hbs_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);
